// ===== src/wtfe_pkg.sv =====
// Shared types and constants of the windowed top-four-by-energy tracker.
package wtfe_pkg;

   localparam int SLOT_COUNT_DEFAULT = 4;
   localparam int SLOT_COUNT_MAX     = 16;

   localparam int TRACK_W  = 9;
   localparam int MASS_W   = 16;
   localparam int ENERGY_W = 18;
   localparam int RANK_W   = $clog2(SLOT_COUNT_MAX);
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [MASS_W-1:0] CENTER_MASS_RESET    = 16'd135;
   localparam logic [MASS_W-1:0] MASS_HALFWIDTH_RESET = 16'd10;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_MASS    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_MASS_HALFWIDTH = 1'b1;

   // command codes
   localparam logic CMD_CLEAR = 1'b0;
   localparam logic CMD_OFFER = 1'b1;

   // token modes
   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_SEARCH = 2'd1;
   localparam logic [1:0] MODE_SHIFT  = 2'd2;
   localparam logic [1:0] MODE_DONE   = 2'd3;

   // token walking down the cell row
   typedef struct packed {
      logic                active;
      logic [1:0]          mode;
      logic                found;
      logic [RANK_W-1:0]   rank;
      logic                carry_valid;
      logic [TRACK_W-1:0]  track;
      logic [ENERGY_W-1:0] energy;
   } token_type;

endpackage

// ===== src/wtfe_cell.sv =====
// One slot cell: holds a track and its energy, processes the passing token.
module wtfe_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wtfe_pkg::token_type           up_tok,
   output wtfe_pkg::token_type           down_tok,
   output logic                          slot_valid,
   output logic [wtfe_pkg::TRACK_W-1:0]  slot_track
);

   logic                          valid_ff, valid_in;
   logic [wtfe_pkg::TRACK_W-1:0]  track_ff, track_in;
   logic [wtfe_pkg::ENERGY_W-1:0] energy_ff, energy_in;
   wtfe_pkg::token_type           down_tok_ff, down_tok_in;

   always_comb begin
      valid_in    = valid_ff;
      track_in    = track_ff;
      energy_in   = energy_ff;
      down_tok_in = up_tok;
      if (up_tok.active) begin
         case (up_tok.mode)
            wtfe_pkg::MODE_CLEAR: begin
               valid_in  = 1'b0;
               track_in  = '0;
               energy_in = '0;
            end
            wtfe_pkg::MODE_SEARCH: begin
               if (!valid_ff) begin
                  valid_in          = 1'b1;
                  track_in          = up_tok.track;
                  energy_in         = up_tok.energy;
                  down_tok_in.mode  = wtfe_pkg::MODE_DONE;
                  down_tok_in.found = 1'b1;
                  down_tok_in.rank  = wtfe_pkg::RANK_W'(CELL_INDEX);
               end else if (track_ff == up_tok.track) begin
                  down_tok_in.mode  = wtfe_pkg::MODE_DONE;
                  down_tok_in.found = 1'b1;
                  down_tok_in.rank  = wtfe_pkg::RANK_W'(CELL_INDEX);
               end else if (up_tok.energy > energy_ff) begin
                  // take the track, old content moves one cell down
                  valid_in                = 1'b1;
                  track_in                = up_tok.track;
                  energy_in               = up_tok.energy;
                  down_tok_in.mode        = wtfe_pkg::MODE_SHIFT;
                  down_tok_in.found       = 1'b1;
                  down_tok_in.rank        = wtfe_pkg::RANK_W'(CELL_INDEX);
                  down_tok_in.carry_valid = valid_ff;
                  down_tok_in.track       = track_ff;
                  down_tok_in.energy      = energy_ff;
               end
            end
            wtfe_pkg::MODE_SHIFT: begin
               valid_in                = up_tok.carry_valid;
               track_in                = up_tok.track;
               energy_in               = up_tok.energy;
               down_tok_in.carry_valid = valid_ff;
               down_tok_in.track       = track_ff;
               down_tok_in.energy      = energy_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         track_ff  <= '0;
         energy_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         track_ff  <= track_in;
         energy_ff <= energy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_tok_ff <= '0;
      end else begin
         down_tok_ff <= down_tok_in;
      end
   end

   assign down_tok   = down_tok_ff;
   assign slot_valid = valid_ff;
   assign slot_track = track_ff;

endmodule

// ===== src/windowed_top_four_by_energy.sv =====
// Top level of the windowed top-four-by-energy tracker.
//
// Keeps the SLOT_COUNT highest-energy tracks (by falling energy) whose mass
// lies strictly inside (center_mass - mass_halfwidth, center_mass +
// mass_halfwidth). A word is taken at a clock edge with start high and busy
// low. An offer word (command 1) is checked against the window at entry and
// then walks as a token down a row of SLOT_COUNT cells, one cell per cycle;
// the first cell that is empty, already holds the same track, or holds a
// lower energy decides, and an insert ripples the displaced tracks one cell
// down behind it. A clear word (command 0) walks the same row and empties
// every cell. The result is strobed on rsp_valid for exactly one cycle;
// the receiver cannot stall it. busy drops in that result cycle, so a new
// word may start there; the block takes no new word while a token walks
// the cell row. The leader fields show the top slot after the word.
// Registers are to be written by the user via csr_we/csr_index/csr_wdata
// only while idle; the block itself does not enforce this.
module windowed_top_four_by_energy #(
   parameter int SLOT_COUNT = wtfe_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // command channel
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_command,
   input  logic [wtfe_pkg::TRACK_W-1:0]      req_track_index,
   input  logic [wtfe_pkg::MASS_W-1:0]       req_track_mass,
   input  logic [wtfe_pkg::ENERGY_W-1:0]     req_track_energy,
   // register writes
   input  logic                              csr_we,
   input  logic [wtfe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [wtfe_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // result strobe
   output logic                              rsp_valid,
   output logic                              rsp_accepted,
   output logic [1:0]                        rsp_placed_rank,
   output logic                              rsp_leader_valid,
   output logic [wtfe_pkg::TRACK_W-1:0]      rsp_leader_track
);

   // config registers
   logic [wtfe_pkg::MASS_W-1:0] center_mass_ff, center_mass_in;
   logic [wtfe_pkg::MASS_W-1:0] halfwidth_ff, halfwidth_in;

   always_comb begin
      center_mass_in = center_mass_ff;
      halfwidth_in   = halfwidth_ff;
      if (csr_we) begin
         unique case (csr_index)
            wtfe_pkg::REG_CENTER_MASS:    center_mass_in = csr_wdata;
            wtfe_pkg::REG_MASS_HALFWIDTH: halfwidth_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_mass_ff <= wtfe_pkg::CENTER_MASS_RESET;
         halfwidth_ff   <= wtfe_pkg::MASS_HALFWIDTH_RESET;
      end else begin
         center_mass_ff <= center_mass_in;
         halfwidth_ff   <= halfwidth_in;
      end
   end

   // mass window, bounds kept wide so nothing wraps
   logic                          take;
   logic [wtfe_pkg::MASS_W+1:0]   win_lo;   // two's complement, may go below zero
   logic [wtfe_pkg::MASS_W:0]     win_hi;
   logic                          above_lo, below_hi, in_window;

   assign take     = start && !busy;
   assign win_lo   = {2'b00, center_mass_ff} - {2'b00, halfwidth_ff};
   assign win_hi   = {1'b0, center_mass_ff} + {1'b0, halfwidth_ff};
   assign above_lo = win_lo[wtfe_pkg::MASS_W+1] || ({2'b00, req_track_mass} > win_lo);
   assign below_hi = {1'b0, req_track_mass} < win_hi;
   assign in_window = above_lo && below_hi;

   // entry token
   wtfe_pkg::token_type entry_ff, entry_in;

   always_comb begin
      entry_in             = entry_ff;
      entry_in.active      = take;
      if (take) begin
         entry_in.found       = 1'b0;
         entry_in.rank        = '0;
         entry_in.carry_valid = 1'b1;
         entry_in.track       = req_track_index;
         entry_in.energy      = req_track_energy;
         if (req_command == wtfe_pkg::CMD_CLEAR) begin
            entry_in.mode = wtfe_pkg::MODE_CLEAR;
         end else if (in_window) begin
            entry_in.mode = wtfe_pkg::MODE_SEARCH;
         end else begin
            entry_in.mode = wtfe_pkg::MODE_DONE;   // rejected, just walks out
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   // cell row: tok[0] feeds cell 0, tok[i+1] leaves cell i
   wtfe_pkg::token_type            tok [SLOT_COUNT+1];
   logic                           head_valid;
   logic [wtfe_pkg::TRACK_W-1:0]   head_track;
   logic [SLOT_COUNT-1:0]          in_flight;

   assign tok[0] = entry_ff;

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      assign in_flight[i] = tok[i].active;
      if (i == 0) begin : g_head
         wtfe_cell #(
            .CELL_INDEX (i)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .up_tok     (tok[i]),
            .down_tok   (tok[i+1]),
            .slot_valid (head_valid),
            .slot_track (head_track)
         );
      end else begin : g_body
         wtfe_cell #(
            .CELL_INDEX (i)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .up_tok     (tok[i]),
            .down_tok   (tok[i+1]),
            .slot_valid (),
            .slot_track ()
         );
      end
   end

   // busy from start edge until the token leaves the last cell
   logic busy_ff, busy_in;

   always_comb begin
      busy_in = busy_ff;
      if (take) begin
         busy_in = 1'b1;
      end else if (tok[SLOT_COUNT-1].active) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy             = busy_ff;
   assign rsp_valid        = tok[SLOT_COUNT].active;
   assign rsp_accepted     = tok[SLOT_COUNT].found;
   assign rsp_placed_rank  = tok[SLOT_COUNT].rank[1:0];
   assign rsp_leader_valid = head_valid;
   assign rsp_leader_track = head_valid ? head_track : '0;

   // checks
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0({in_flight, tok[SLOT_COUNT].active}))
      else $error("more than one token in the cell row");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (in_flight == '0))
      else $error("token in flight while not busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      take |=> busy)
      else $error("busy not raised after start");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result strobe outside a word's end");

   a_top_leader: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> rsp_leader_valid)
      else $error("track accepted but top slot empty");

endmodule
